// ----- rtl/core/lspcp_pkg.sv -----
// Shared constants, types and helpers for the pixel channel packer.
`timescale 1ns / 1ps
package lspcp_pkg;
  localparam int SampleBits = 8;
  localparam int NumCh = 4;
  localparam int DivBits = 16;
  localparam int ShBits = 6;
  localparam int WordBits = 64;
  localparam int NumSteps = SampleBits + 1;

  localparam logic [2:0] RegDiv0 = 3'd0;
  localparam logic [2:0] RegDiv1 = 3'd1;
  localparam logic [2:0] RegDiv2 = 3'd2;
  localparam logic [2:0] RegDiv3 = 3'd3;
  localparam logic [2:0] RegShift = 3'd4;
  localparam logic [2:0] RegWidth = 3'd5;
  localparam logic [2:0] RegChMode = 3'd6;

  localparam logic [1:0] ModeOne = 2'd0;
  localparam logic [1:0] ModeTwo = 2'd1;
  localparam logic [1:0] ModeFour = 2'd2;

  localparam logic [1:0] Width8 = 2'd0;
  localparam logic [1:0] Width16 = 2'd1;
  localparam logic [1:0] Width32 = 2'd2;
  localparam logic [1:0] Width64 = 2'd3;

  localparam logic [0:0] OpPack = 1'b0;
  localparam logic [0:0] OpTable = 1'b1;

  // Per-stage status carried down the pipe.
  typedef struct packed {
    logic valid;
    logic [1:0] width_code;
  } ctl_t;

  function automatic logic [WordBits-1:0] width_mask(input logic [1:0] code);
    logic [WordBits-1:0] m;
    case (code)
      Width8: m = 64'h0000_0000_0000_00FF;
      Width16: m = 64'h0000_0000_0000_FFFF;
      Width32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction
endpackage

// ----- rtl/core/lspcp_lane.sv -----
// One channel lane: pipelined restoring divide, table lookup, shift.
`timescale 1ns / 1ps
module lspcp_lane (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic [lspcp_pkg::SampleBits-1:0] sample,
  input  logic [lspcp_pkg::DivBits-1:0] divisor,
  input  logic [lspcp_pkg::ShBits-1:0] shamt,
  input  logic active,
  input  logic wr_en,
  input  logic [lspcp_pkg::SampleBits-1:0] wr_addr,
  input  logic [7:0] wr_data,
  output logic [lspcp_pkg::WordBits-1:0] term
);
  localparam int NB = lspcp_pkg::NumSteps;
  localparam int DB = lspcp_pkg::DivBits;
  localparam int S = lspcp_pkg::SampleBits;

  // dividend x + d/2 fits in NB+DB-1 bits; quotient fits in NB bits
  logic [NB-1:0] num [NB+1];
  logic [DB:0] rem [NB+1];
  logic [DB-1:0] dv [NB+1];
  logic [NB-1:0] quo [NB+1];
  logic [lspcp_pkg::ShBits-1:0] sh [NB+1];
  logic act [NB+1];
  // table writes ride the pipe so they land in stream order
  logic w_en [NB+1];
  logic [S-1:0] w_addr [NB+1];
  logic [7:0] w_data [NB+1];

  logic [DB-1:0] d_eff;
  logic [DB:0] dend;
  logic [7:0] mem [2**S];
  logic [7:0] rd;
  logic [lspcp_pkg::ShBits-1:0] sh_l;
  logic act_l;

  assign d_eff = (divisor == '0) ? DB'(1) : divisor;
  assign dend = (DB+1)'(sample) + (DB+1)'(d_eff >> 1);

  // Stage 0: low NB dividend bits shift in; high bits seed the remainder
  // (quotient < 2^NB, so dend >> NB is already below d).
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= (DB+1)'(dend >> NB);
      num[0] <= NB'(dend);
      quo[0] <= '0;
      dv[0] <= d_eff;
      sh[0] <= shamt;
      act[0] <= active;
      w_addr[0] <= wr_addr;
      w_data[0] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) w_en[k] <= 1'b0;
    end else if (adv) begin
      w_en[0] <= wr_en;
      for (int k = 1; k <= NB; k++) w_en[k] <= w_en[k-1];
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_step
    logic [DB+1:0] trial;
    assign trial = {rem[i][DB:0], num[i][NB-1]} - {1'b0, 1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[DB+1]) begin
          rem[i+1] <= trial[DB:0];
          quo[i+1] <= {quo[i][NB-2:0], 1'b1};
        end else begin
          rem[i+1] <= {rem[i][DB-1:0], num[i][NB-1]};
          quo[i+1] <= {quo[i][NB-2:0], 1'b0};
        end
        num[i+1] <= {num[i][NB-2:0], 1'b0};
        dv[i+1] <= dv[i];
        sh[i+1] <= sh[i];
        act[i+1] <= act[i];
        w_addr[i+1] <= w_addr[i];
        w_data[i+1] <= w_data[i];
      end
    end
  end

  // table write and registered read at the same stage
  always_ff @(posedge clk) begin
    if (adv) begin
      if (w_en[NB]) mem[w_addr[NB]] <= w_data[NB];
      rd <= mem[quo[NB][S-1:0]];
      sh_l <= sh[NB];
      act_l <= act[NB];
    end
  end

  assign term = act_l ? (lspcp_pkg::WordBits'(rd) << sh_l) : '0;
endmodule

// ----- rtl/core/lspcp_merge.sv -----
// Merge stage: sums the lane terms and applies the width mask.
`timescale 1ns / 1ps
module lspcp_merge (
  input  logic clk,
  input  logic adv,
  input  logic [lspcp_pkg::WordBits-1:0] t0,
  input  logic [lspcp_pkg::WordBits-1:0] t1,
  input  logic [lspcp_pkg::WordBits-1:0] t2,
  input  logic [lspcp_pkg::WordBits-1:0] t3,
  input  logic [1:0] width_code,
  output logic [lspcp_pkg::WordBits-1:0] sum
);
  logic [lspcp_pkg::WordBits-1:0] s01, s23;
  logic [1:0] wc;
  always_ff @(posedge clk) begin
    if (adv) begin
      s01 <= t0 + t1;
      s23 <= t2 + t3;
      wc <= width_code;
    end
  end
  assign sum = (s01 + s23) & lspcp_pkg::width_mask(wc);
endmodule

// ----- rtl/core/lut_scaled_pixel_channel_packer_top.sv -----
// Top level of the LUT-scaled pixel channel packer.
// Stages: input register, divide steps, table read, merge register.
// Throughput: one word per cycle; the pipe stalls as one when the output
// register is full and stalled. Table writes travel the same pipe and
// update the table at its read stage, so they keep stream order.
// Reset (rst, synchronous): clears valid flags and restores registers;
// scale tables are not cleared.
`timescale 1ns / 1ps
module lut_scaled_pixel_channel_packer_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic mode,
  input  logic [1:0] table_select,
  input  logic [7:0] table_index,
  input  logic [7:0] table_value,
  input  logic [7:0] sample_ch0,
  input  logic [7:0] sample_ch1,
  input  logic [7:0] sample_ch2,
  input  logic [7:0] sample_ch3,
  output logic out_valid,
  input  logic out_stall,
  output logic [63:0] packed_word
);
  // Pipe depth: input reg, NumSteps divide steps, table read, merge reg.
  localparam int Depth = lspcp_pkg::NumSteps + 3;

  logic [15:0] div_r [lspcp_pkg::NumCh];
  logic [23:0] shift_word;
  logic [1:0] out_width_code;
  logic [1:0] channel_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < lspcp_pkg::NumCh; c++) div_r[c] <= 16'd1;
      shift_word <= '0;
      out_width_code <= lspcp_pkg::Width32;
      channel_mode <= lspcp_pkg::ModeFour;
    end else if (cfg_we) begin
      case (cfg_index)
        lspcp_pkg::RegDiv0: div_r[0] <= cfg_data[15:0];
        lspcp_pkg::RegDiv1: div_r[1] <= cfg_data[15:0];
        lspcp_pkg::RegDiv2: div_r[2] <= cfg_data[15:0];
        lspcp_pkg::RegDiv3: div_r[3] <= cfg_data[15:0];
        lspcp_pkg::RegShift: shift_word <= cfg_data;
        lspcp_pkg::RegWidth: out_width_code <= cfg_data[1:0];
        lspcp_pkg::RegChMode: channel_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; a stalled full output freezes it.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic acc, is_pack, is_wr;
  assign acc = in_valid && adv;
  assign is_pack = acc && (mode == lspcp_pkg::OpPack);
  assign is_wr = acc && (mode != lspcp_pkg::OpPack);

  // valid and width code travel alongside the lanes
  lspcp_pkg::ctl_t ctl [Depth];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Depth; k++) ctl[k].valid <= 1'b0;
    end else if (adv) begin
      ctl[0].valid <= is_pack;
      for (int k = 1; k < Depth; k++) ctl[k].valid <= ctl[k-1].valid;
    end
    if (adv) begin
      ctl[0].width_code <= out_width_code;
      for (int k = 1; k < Depth; k++) ctl[k].width_code <= ctl[k-1].width_code;
    end
  end

  logic [3:0] act;
  always_comb begin
    case (channel_mode)
      lspcp_pkg::ModeOne: act = 4'b0001;
      lspcp_pkg::ModeTwo: act = 4'b0011;
      default: act = 4'b1111;
    endcase
  end

  logic [7:0] smp [lspcp_pkg::NumCh];
  assign smp[0] = sample_ch0;
  assign smp[1] = sample_ch1;
  assign smp[2] = sample_ch2;
  assign smp[3] = sample_ch3;

  logic [63:0] term [lspcp_pkg::NumCh];
  for (genvar c = 0; c < lspcp_pkg::NumCh; c++) begin : g_lane
    lspcp_lane u_lane (
      .clk(clk), .rst(rst), .adv(adv), .sample(smp[c]), .divisor(div_r[c]),
      .shamt(shift_word[6*c +: 6]), .active(act[c]),
      .wr_en(is_wr && (table_select == 2'(c))),
      .wr_addr(table_index), .wr_data(table_value), .term(term[c])
    );
  end

  lspcp_merge u_merge (
    .clk(clk), .adv(adv), .t0(term[0]), .t1(term[1]), .t2(term[2]),
    .t3(term[3]), .width_code(ctl[Depth-2].width_code), .sum(packed_word)
  );

  assign out_valid = ctl[Depth-1].valid;
endmodule
